// File: rtl/job_min_heap_queue_defines.svh
// Assertion macros for the job heap queue
`ifndef JOB_MIN_HEAP_QUEUE_DEFINES_SVH
`define JOB_MIN_HEAP_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define JMHQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define JMHQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define JMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/jmhq_pkg.sv
package jmhq_pkg;

  localparam int unsigned QueueDepthDefault = 1024;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_UPDATE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] priority_req;
    logic [7:0]  task_id;
    logic [15:0] job_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_task_id;
    logic [15:0] out_job_number;
    logic [31:0] out_priority;
    logic [10:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  tid;
    logic [15:0] jno;
  } slot_t;

endpackage

// File: rtl/jmhq_store.sv
module jmhq_store #(
  parameter int unsigned AddrW = 10
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  jmhq_pkg::slot_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output jmhq_pkg::slot_t     rdata_o
);
  import jmhq_pkg::*;

  slot_t mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/job_min_heap_queue.sv
// Job min-heap priority queue, one operation in flight; the input stalls while busy.
// Insert sifts the new entry up; extract reads the root and, if entries remain, moves the last
//   entry to the root and sifts it down; remove/update search the entries in order, then remove
//   moves the last entry into the hole and sifts it up and down, update sifts the changed entry.
// A new operation is accepted only after the result is taken; the single-read-port heap RAM
//   sets the pace. Reset: async active low; clears count and control, heap RAM is not cleared.
`include "job_min_heap_queue_defines.svh"
module job_min_heap_queue #(
  parameter int unsigned QUEUE_DEPTH = jmhq_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  jmhq_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output jmhq_pkg::rsp_t  out_data_o
);
  import jmhq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_ROOT_RD, S_EXT_CAP, S_LAST_RD, S_LAST_CAP,
    S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_OUT
  } state_e;

  state_e state_q;
  req_t   req_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] i_q, j_q;
  slot_t  cur_q, lft_q;
  logic   rv_q;
  logic   dn_after_q;
  logic   moved_q;
  rsp_t   rsp_q;
  logic   busy_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata;

  logic [IW-1:0] par, lch, rch;
  logic          up_to_dn, up_move, lch_ok;
  logic          dn_l_lt, dn_r_lt, dn_move;
  logic [31:0]   dn_min_key;
  slot_t         dn_child;

  jmhq_store #(.AddrW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  assign par = (i_q - IW'(1)) >> 1;
  assign lch = {i_q[IW-2:0], 1'b1};
  assign rch = lch + IW'(1);

  // sift down follows sift up only for remove/update, and only when sift up left the entry in place
  assign up_to_dn   = dn_after_q & ~moved_q;
  assign up_move    = cur_q.key < rdata.key;
  assign lch_ok     = lch < IW'(cnt_q);
  assign dn_l_lt    = lft_q.key < cur_q.key;
  assign dn_min_key = dn_l_lt ? lft_q.key : cur_q.key;
  assign dn_r_lt    = rv_q & (rdata.key < dn_min_key);
  assign dn_move    = dn_l_lt | dn_r_lt;
  assign dn_child   = dn_r_lt ? rdata : lft_q;

  // memory address and write control, driven from state; cur_q floats in a hole at i_q
  always_comb begin
    we = 1'b0; waddr = i_q[AW-1:0]; wdata = cur_q; raddr = i_q[AW-1:0];
    case (state_q)
      S_FIND_RD:  raddr = j_q[AW-1:0];
      S_ROOT_RD:  raddr = '0;
      S_LAST_RD:  raddr = AW'(cnt_q);
      S_UP_RD: begin
        if (i_q == '0) we = ~up_to_dn;
        else raddr = par[AW-1:0];
      end
      S_UP_CMP: begin
        if (up_move) begin
          we = 1'b1; wdata = rdata;
        end else begin
          we = ~up_to_dn;
        end
      end
      S_DN_RDL: begin
        if (lch_ok) raddr = lch[AW-1:0];
        else we = 1'b1;
      end
      S_DN_RDR:   raddr = rch[AW-1:0];
      S_DN_CMP: begin
        we = 1'b1;
        if (dn_move) wdata = dn_child;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; busy_q <= 1'b0; cnt_q <= '0; req_q <= '0; rsp_q <= '0;
      i_q <= '0; j_q <= '0; cur_q <= '0; lft_q <= '0; rv_q <= 1'b0;
      dn_after_q <= 1'b0; moved_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i; busy_q <= 1'b1;
            rsp_q.out_task_id <= '0;
            rsp_q.out_job_number <= '0;
            rsp_q.out_priority <= '0;
            j_q <= '0; i_q <= '0; moved_q <= 1'b0;
            dn_after_q <= (op_e'(in_data_i.operation) != OP_INSERT);
            case (op_e'(in_data_i.operation))
              OP_INSERT: begin
                if (cnt_q == CW'(QUEUE_DEPTH)) begin
                  rsp_q.status <= ST_FULL; rsp_q.entry_count <= 11'(cnt_q);
                  state_q <= S_OUT;
                end else begin
                  cur_q <= '{key: in_data_i.priority_req, tid: in_data_i.task_id,
                             jno: in_data_i.job_number};
                  i_q <= IW'(cnt_q); cnt_q <= cnt_q + CW'(1);
                  rsp_q.status <= ST_DONE;
                  rsp_q.entry_count <= 11'(cnt_q + CW'(1));
                  state_q <= S_UP_RD;
                end
              end
              OP_EXTRACT: begin
                rsp_q.entry_count <= 11'(cnt_q);
                if (cnt_q == '0) begin
                  rsp_q.status <= ST_EMPTY; state_q <= S_OUT;
                end else begin
                  rsp_q.status <= ST_DONE; state_q <= S_ROOT_RD;
                end
              end
              default: begin
                rsp_q.entry_count <= 11'(cnt_q);
                if (cnt_q == '0) begin
                  rsp_q.status <= ST_NOT_FOUND; state_q <= S_OUT;
                end else begin
                  rsp_q.status <= ST_DONE; state_q <= S_FIND_RD;
                end
              end
            endcase
          end
        end
        S_ROOT_RD: state_q <= S_EXT_CAP;
        S_EXT_CAP: begin
          rsp_q.out_task_id <= rdata.tid;
          rsp_q.out_job_number <= rdata.jno;
          rsp_q.out_priority <= rdata.key;
          cnt_q <= cnt_q - CW'(1);
          rsp_q.entry_count <= 11'(cnt_q - CW'(1));
          if (cnt_q == CW'(1)) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_LAST_RD;
          end
        end
        S_FIND_RD: state_q <= S_FIND_CMP;
        S_FIND_CMP: begin
          if (rdata.tid == req_q.task_id && rdata.jno == req_q.job_number) begin
            i_q <= j_q;
            if (op_e'(req_q.operation) == OP_UPDATE) begin
              cur_q <= '{key: req_q.priority_req, tid: rdata.tid, jno: rdata.jno};
              state_q <= S_UP_RD;
            end else begin
              cnt_q <= cnt_q - CW'(1);
              rsp_q.entry_count <= 11'(cnt_q - CW'(1));
              if (j_q == IW'(cnt_q - CW'(1))) begin
                state_q <= S_OUT; // removed the last slot
              end else begin
                state_q <= S_LAST_RD;
              end
            end
          end else if (j_q + IW'(1) >= IW'(cnt_q)) begin
            rsp_q.status <= ST_NOT_FOUND; state_q <= S_OUT;
          end else begin
            j_q <= j_q + IW'(1); state_q <= S_FIND_RD;
          end
        end
        // cnt_q already decremented, so it indexes the last entry
        S_LAST_RD: state_q <= S_LAST_CAP;
        S_LAST_CAP: begin
          cur_q <= rdata;
          state_q <= (op_e'(req_q.operation) == OP_EXTRACT) ? S_DN_RDL : S_UP_RD;
        end
        S_UP_RD: begin
          if (i_q == '0) state_q <= up_to_dn ? S_DN_RDL : S_OUT;
          else state_q <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            i_q <= par; moved_q <= 1'b1; // parent moves down into the hole
            state_q <= S_UP_RD;
          end else begin
            state_q <= up_to_dn ? S_DN_RDL : S_OUT;
          end
        end
        S_DN_RDL: begin
          if (lch_ok) state_q <= S_DN_RDR;
          else state_q <= S_OUT;
        end
        S_DN_RDR: begin
          lft_q <= rdata;
          rv_q <= (rch < IW'(cnt_q));
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            i_q <= dn_r_lt ? rch : lch;
            state_q <= S_DN_RDL;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE; busy_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `JMHQ_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, cnt_q <= CW'(QUEUE_DEPTH), "count over depth")
  `JMHQ_ASSERT_IMPL(a_busy_idle, clk_i, rst_ni, (state_q == S_IDLE) == !busy_q, "busy flag off")
  `JMHQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(rsp_q), "moved")
  `JMHQ_ASSERT_NEXT(a_out_keep, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "dropped")

endmodule

// File: tb/job_min_heap_queue_tb.sv
`timescale 1ns / 100ps
module job_min_heap_queue_tb;
  import jmhq_pkg::*;

  localparam int unsigned Depth = QueueDepthDefault;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  rsp_t out_data;

  job_min_heap_queue dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow heap of queued jobs
  slot_t shadow_heap [Depth];
  int unsigned job_count = 0;
  rsp_t pending_rsp [$];

  int unsigned mismatches = 0;
  int unsigned beats_out = 0;
  int unsigned status_seen [4];
  int unsigned hold_off = 0;

  function automatic void swap_jobs(int unsigned a, int unsigned b);
    slot_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned idx);
    int unsigned p;
    while (idx > 0) begin
      p = (idx - 1) / 2;
      if (shadow_heap[idx].key < shadow_heap[p].key) begin
        swap_jobs(idx, p);
        idx = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void bubble_down(int unsigned idx);
    int unsigned l, r, m;
    forever begin
      l = 2 * idx + 1;
      r = 2 * idx + 2;
      m = idx;
      if (l < job_count && shadow_heap[l].key < shadow_heap[m].key) m = l;
      if (r < job_count && shadow_heap[r].key < shadow_heap[m].key) m = r;
      if (m == idx) break;
      swap_jobs(idx, m);
      idx = m;
    end
  endfunction

  function automatic rsp_t predict_queue_op(req_t r);
    rsp_t res;
    int unsigned idx;
    res = '0;
    res.status = ST_DONE;
    case (op_e'(r.operation))
      OP_INSERT: begin
        if (job_count < Depth) begin
          shadow_heap[job_count] = '{key: r.priority_req, tid: r.task_id, jno: r.job_number};
          bubble_up(job_count);
          job_count++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_EXTRACT: begin
        if (job_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_task_id = shadow_heap[0].tid;
          res.out_job_number = shadow_heap[0].jno;
          res.out_priority = shadow_heap[0].key;
          job_count--;
          shadow_heap[0] = shadow_heap[job_count];
          bubble_down(0);
        end
      end
      default: begin
        idx = job_count;
        for (int unsigned i = 0; i < job_count; i++) begin
          if (shadow_heap[i].tid == r.task_id && shadow_heap[i].jno == r.job_number) begin
            idx = i;
            break;
          end
        end
        if (idx >= job_count) begin
          res.status = ST_NOT_FOUND;
        end else if (op_e'(r.operation) == OP_REMOVE) begin
          job_count--;
          if (idx < job_count) begin
            shadow_heap[idx] = shadow_heap[job_count];
            bubble_up(idx);
            bubble_down(idx);
          end
        end else begin
          shadow_heap[idx].key = r.priority_req;
          bubble_up(idx);
          bubble_down(idx);
        end
      end
    endcase
    res.entry_count = 11'(job_count);
    return res;
  endfunction

  // one request beat; valid stays up after acceptance for back-to-back beats
  task automatic send_req(op_e op, logic [31:0] key, logic [7:0] tid, logic [15:0] jno);
    int unsigned gap;
    req_t r;
    gap = $urandom_range(0, 12);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.operation = op;
    r.priority_req = key;
    r.task_id = tid;
    r.job_number = jno;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(predict_queue_op(r));
  endtask

  task automatic drain;
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_rsp.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // response side: random stalls, optional long hold-off
  initial begin
    int unsigned n;
    rsp_t want;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      beats_out++;
      status_seen[out_data.status]++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat %p", out_data);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected st=%0d tid=%0h jno=%0h pri=%0h cnt=%0d",
                     want.status, want.out_task_id, want.out_job_number,
                     want.out_priority, want.entry_count);
            $display("          got      st=%0d tid=%0h jno=%0h pri=%0h cnt=%0d",
                     out_data.status, out_data.out_task_id, out_data.out_job_number,
                     out_data.out_priority, out_data.entry_count);
          end
        end
      end
    end
  end

  task automatic test_corner_cases;
    send_req(OP_EXTRACT, 32'h0, 8'h0, 16'h0);
    send_req(OP_REMOVE, 32'h0, 8'h12, 16'h34);
    send_req(OP_UPDATE, 32'h5, 8'h12, 16'h34);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_req(OP_INSERT, 32'h0, 8'h00, 16'h0000);
    send_req(OP_INSERT, 32'h100, 8'hA5, 16'h5A5A);
    send_req(OP_INSERT, 32'h100, 8'h5A, 16'hA5A5);
    // same id twice: only the first match is touched
    send_req(OP_INSERT, 32'h80, 8'h07, 16'h0007);
    send_req(OP_INSERT, 32'h40, 8'h07, 16'h0007);
    send_req(OP_UPDATE, 32'hFFFF_FFFE, 8'h07, 16'h0007);
    send_req(OP_REMOVE, 32'h0, 8'h07, 16'h0007);
    send_req(OP_UPDATE, 32'h0, 8'hFF, 16'hFFFF);
    send_req(OP_REMOVE, 32'h0, 8'h99, 16'h9999);
    // hole at the last slot
    send_req(OP_INSERT, 32'hFFFF_FFFF, 8'h33, 16'h3333);
    send_req(OP_REMOVE, 32'h0, 8'h33, 16'h3333);
    repeat (8) send_req(OP_EXTRACT, 32'h0, 8'h0, 16'h0);
    drain();
  endtask

  task automatic test_fill_to_capacity;
    hold_off = 600;
    for (int unsigned i = 0; i < Depth; i++)
      send_req(OP_INSERT, $urandom_range(0, 255), 8'(i), 16'(i >> 3));
    send_req(OP_INSERT, 32'h0, 8'hEE, 16'hEEEE);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 8'hEF, 16'hEEEF);
    send_req(OP_UPDATE, 32'h0, 8'(Depth - 1), 16'((Depth - 1) >> 3));
    send_req(OP_REMOVE, 32'h0, 8'd3, 16'd0);
    send_req(OP_INSERT, 32'h7, 8'hEE, 16'hEEEE);
    drain();
  endtask

  // runs on the full queue left by the fill test
  task automatic test_random_mix;
    int unsigned pick, k;
    logic [31:0] key;
    logic [7:0] tid;
    logic [15:0] jno;
    for (int unsigned n = 0; n < 50; n++) begin
      pick = $urandom_range(0, 99);
      key = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) begin
        tid = 8'($urandom());
        jno = 16'($urandom());
      end else begin
        tid = 8'($urandom_range(0, 7));
        jno = 16'($urandom_range(0, 3));
      end
      if (job_count > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, job_count - 1);
        if (pick >= 60) begin
          tid = shadow_heap[k].tid;
          jno = shadow_heap[k].jno;
        end
      end
      if (job_count > 48 && pick < 40) pick = 45;
      if (pick < 40) send_req(OP_INSERT, key, tid, jno);
      else if (pick < 65) send_req(OP_EXTRACT, key, tid, jno);
      else if (pick < 80) send_req(OP_REMOVE, key, tid, jno);
      else send_req(OP_UPDATE, key, tid, jno);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_fill_to_capacity();
    test_random_mix();
    $display("checked %0d response beats: %0d done, %0d empty, %0d full, %0d not found",
             beats_out, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("covered directed corners, a full queue under back-pressure and a random mix");
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("job_min_heap_queue verification clean");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp.size());
      $display("job_min_heap_queue verification failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout");
    $display("job_min_heap_queue verification failed");
    $finish;
  end

endmodule
